/* design/nepr_pkg.sv */
// Shared types and constants of the note envelope phase rate block.
package nepr_pkg;

	localparam int unsigned TIME_BITS = 32;
	localparam int unsigned RATE_FRAC_BITS = 16;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned RATE_W = RATE_FRAC_BITS + 1;
	localparam int unsigned K_W = RATE_FRAC_BITS + 3;
	localparam int unsigned BASE_W = RATE_FRAC_BITS + 4;
	localparam int unsigned NUM_CELLS = K_W;
	localparam int unsigned ONE_INT = 1 << RATE_FRAC_BITS;
	localparam int unsigned DIV_SH = BASE_W;
	localparam int unsigned RECIP_INT = (1 << DIV_SH) / 10;
	localparam int unsigned PROD_W = BASE_W + BASE_W;

	localparam logic [K_W-1:0] K_THREE = K_W'(3 * ONE_INT);
	localparam logic [K_W-1:0] K_FOUR = K_W'(4 * ONE_INT);
	localparam logic [K_W-1:0] K_FIVE = K_W'(5 * ONE_INT);
	localparam logic [BASE_W-1:0] B_THREE = BASE_W'(3 * ONE_INT);
	localparam logic [BASE_W-1:0] B_FIVE = BASE_W'(5 * ONE_INT);
	localparam logic [BASE_W-1:0] B_SEVEN = BASE_W'(7 * ONE_INT);
	localparam logic [BASE_W-1:0] B_TEN = BASE_W'(10 * ONE_INT);
	localparam logic [BASE_W-1:0] RECIP = BASE_W'(RECIP_INT);
	localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(ONE_INT);
	localparam logic [RATE_W-1:0] RATE_HALF = RATE_W'(ONE_INT / 2);
	localparam logic [RATE_W-1:0] RATE_SUS_MAX = RATE_W'((7 * ONE_INT) / 10);

	localparam logic [CFG_IDX_W-1:0] CFG_DECAY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = CFG_IDX_W'(1);

	typedef logic [TIME_BITS-1:0] time_t;

	typedef enum logic [1:0] {
		PH_DECAY   = 2'd0,
		PH_SUSTAIN = 2'd1,
		PH_RELEASE = 2'd2
	} phase_t;

	// Work carried along the divider chain.
	typedef struct packed {
		time_t             den;
		time_t             num;
		time_t             rem;
		logic [K_W-1:0]    quo;
		logic [K_W-1:0]    k;
		logic [BASE_W-1:0] base;
		phase_t            phase;
	} cell_pl_t;

endpackage

/* design/nepr_if.sv */
// Channel interfaces of the note envelope phase rate block.
interface nepr_note_if import nepr_pkg::*;;
	logic  valid;
	logic  ready;
	time_t play_time;
	time_t note_start;
	time_t note_end;
	modport source(output valid, play_time, note_start, note_end, input ready);
	modport sink(input valid, play_time, note_start, note_end, output ready);
endinterface

interface nepr_rate_if import nepr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] key_rate;
	logic [1:0]        key_phase;
	modport source(output valid, key_rate, key_phase, input ready);
	modport sink(input valid, key_rate, key_phase, output ready);
endinterface

interface nepr_cfg_if import nepr_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* design/note_envelope_phase_rate_core.sv */
// Top level of the note envelope phase rate block.
// Channels: notes carries play_time, note_start and note_end; rates returns
// key_rate (65536 is 1.0) and key_phase; cfg writes decay_time (index 0) and
// release_time (index 1), and writes to other indexes are dropped. cfg is
// always ready and must only be used while no transaction is in flight.
// Each note gives exactly one result, in order.
// Pipeline: 3 front stages, one cell per multiplier bit (19 cells at 16
// fraction bits), then a reciprocal multiply and a correction stage.
// Throughput: one note per cycle while the receiver keeps up; the divider is a chain of cells, each
// of which resolves one quotient bit and passes its work on every enabled cycle.
// When the receiver stalls, the whole pipeline holds and notes.ready drops
// only while a result waits at the output register.
// Reset clears all valid flags and loads decay 100 ms and release 250 ms.
module note_envelope_phase_rate_core import nepr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	nepr_note_if.sink   notes,
	nepr_rate_if.source rates,
	nepr_cfg_if.sink    cfg
);
	logic [CFG_W-1:0] decay_q, release_q;
	logic             en;
	logic             cv [NUM_CELLS+1];
	cell_pl_t         cp [NUM_CELLS+1];
	logic                v_m;
	logic [BASE_W-1:0]   total, total_m, est_m, fix;
	logic [PROD_W-1:0]   prod;
	phase_t              phase_m, phase_q;
	logic [RATE_W-1:0]   rate_q;
	logic                out_v_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= CFG_W'(100);
			release_q <= CFG_W'(250);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_DECAY: decay_q <= cfg.data;
				CFG_RELEASE: release_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign en = !out_v_q || rates.ready;
	assign notes.ready = en;

	nepr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(notes.valid),
		.play_time(notes.play_time),
		.note_start(notes.note_start),
		.note_end(notes.note_end),
		.decay_time(decay_q),
		.release_time(release_q),
		.out_valid(cv[0]),
		.out_pl(cp[0])
	);

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		nepr_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(cv[i]),
			.in_pl(cp[i]),
			.out_valid(cv[i+1]),
			.out_pl(cp[i+1])
		);
	end

	// Division by ten: a reciprocal estimate, low by at most one, then one correction.
	assign total = cp[NUM_CELLS].base + BASE_W'(cp[NUM_CELLS].quo);
	assign prod = PROD_W'(total) * PROD_W'(RECIP);
	assign fix = total_m - ((est_m << 3) + (est_m << 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_m <= cv[NUM_CELLS];
			out_v_q <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			total_m <= total;
			est_m <= BASE_W'(prod >> DIV_SH);
			phase_m <= cp[NUM_CELLS].phase;
			rate_q <= (fix >= BASE_W'(10)) ? RATE_W'(est_m + BASE_W'(1)) : RATE_W'(est_m);
			phase_q <= phase_m;
		end
	end

	assign rates.valid = out_v_q;
	assign rates.key_rate = rate_q;
	assign rates.key_phase = 2'(phase_q);

	a_rate_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> rate_q <= RATE_ONE)
		else $error("key rate above one");
	a_release_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && phase_q == PH_RELEASE) |-> rate_q >= RATE_HALF)
		else $error("release rate below the sustain level");
	a_sustain_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && phase_q == PH_SUSTAIN) |-> rate_q <= RATE_SUS_MAX)
		else $error("sustain rate above its end level");

endmodule

/* design/nepr_front.sv */
// Front stages: time repair, note length classification and divider set-up.
module nepr_front import nepr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  time_t            play_time,
	input  time_t            note_start,
	input  time_t            note_end,
	input  logic [CFG_W-1:0] decay_time,
	input  logic [CFG_W-1:0] release_time,
	output logic             out_valid,
	output cell_pl_t         out_pl
);
	localparam int unsigned TW = TIME_BITS;

	logic  v_s1, v_s2;
	time_t start_s1, end_s1, play_s1;
	time_t len_s2, x_s2, d_s2, r_s2;
	logic  five_s2, after_s2;

	time_t              len, x, d2, r2, mid, end_m_r;
	logic               after, five;
	logic [TW+1:0]      len_w, dc_w, rc_w, sum_w;
	logic [TW:0]        start_d, mid_w;
	time_t              lmr, den;
	logic [K_W-1:0]     kd, ks, kr;
	logic [BASE_W-1:0]  bd, bds;
	cell_pl_t           pl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	// Stage 1: an end before the start, or a play time before it, is pulled up to the start.
	always_ff @(posedge clk) begin
		if (en) begin
			start_s1 <= note_start;
			end_s1 <= (note_end < note_start) ? note_start : note_end;
			play_s1 <= (play_time < note_start) ? note_start : play_time;
		end
	end

	always_comb begin
		len = end_s1 - start_s1;
		x = play_s1 - start_s1;
		after = play_s1 > end_s1;
		len_w = (TW+2)'(len);
		dc_w = (TW+2)'(decay_time);
		rc_w = (TW+2)'(release_time);
		sum_w = dc_w + rc_w;
		start_d = (TW+1)'(start_s1) + (TW+1)'(decay_time);
		end_m_r = end_s1 - TW'(release_time);
		mid_w = (start_d >> 1) + (TW+1)'(end_m_r >> 1);
		mid = (mid_w < (TW+1)'(start_s1)) ? start_s1 : TW'(mid_w);
		d2 = TW'(decay_time);
		r2 = TW'(release_time);
		five = 1'b0;
		if (len_w < dc_w) begin
			five = 1'b0;
		end else if (len_w < sum_w) begin
			r2 = len - TW'(decay_time);
			five = 1'b1;
		end else if (len_w < (sum_w << 1)) begin
			d2 = mid - start_s1;
			r2 = end_s1 - mid;
			five = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s2 <= len;
			x_s2 <= x;
			d_s2 <= d2;
			r_s2 <= r2;
			five_s2 <= five;
			after_s2 <= after;
		end
	end

	// Stage 3: pick the phase and the single quotient that gives its rate.
	always_comb begin
		lmr = len_s2 - r_s2;
		den = lmr - d_s2;
		kd = five_s2 ? K_FIVE : K_THREE;
		ks = five_s2 ? '0 : K_FOUR;
		kr = five_s2 ? K_FIVE : K_THREE;
		bd = five_s2 ? B_FIVE : B_THREE;
		bds = five_s2 ? B_FIVE : B_SEVEN;
		pl.rem = '0;
		pl.quo = '0;
		pl.den = TW'(1);
		pl.num = '0;
		pl.k = '0;
		pl.base = '0;
		pl.phase = PH_DECAY;
		if (after_s2) begin
			pl.phase = PH_DECAY;
		end else if (x_s2 < d_s2) begin
			pl.k = kd;
			pl.den = d_s2;
			pl.num = x_s2;
		end else if (x_s2 <= lmr) begin
			pl.phase = PH_SUSTAIN;
			if (den == '0) begin
				pl.base = bds;
			end else begin
				pl.base = bd;
				pl.k = ks;
				pl.den = den;
				pl.num = x_s2 - d_s2;
			end
		end else begin
			pl.phase = PH_RELEASE;
			if (r_s2 == '0) begin
				pl.base = B_TEN;
			end else begin
				pl.base = bds;
				pl.k = kr;
				pl.den = r_s2;
				pl.num = x_s2 - lmr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pl <= pl;
		end
	end

endmodule

/* design/nepr_cell.sv */
// One cell of the scaled divider chain: takes one bit of the multiplier per cycle while en is high.
module nepr_cell import nepr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  cell_pl_t in_pl,
	output logic     out_valid,
	output cell_pl_t out_pl
);
	cell_pl_t nx;
	time_t    dmr, dmx;

	// The remainder is kept below the divisor, so differences avoid any overflow.
	always_comb begin
		nx = in_pl;
		nx.quo = {in_pl.quo[K_W-2:0], 1'b0};
		dmr = in_pl.den - in_pl.rem;
		if (in_pl.rem >= dmr) begin
			nx.rem = in_pl.rem - dmr;
			nx.quo = nx.quo + K_W'(1);
		end else begin
			nx.rem = in_pl.rem + in_pl.rem;
		end
		dmx = in_pl.den - in_pl.num;
		if (in_pl.k[K_W-1]) begin
			if (in_pl.num == in_pl.den) begin
				nx.quo = nx.quo + K_W'(1);
			end else if (nx.rem >= dmx) begin
				nx.rem = nx.rem - dmx;
				nx.quo = nx.quo + K_W'(1);
			end else begin
				nx.rem = nx.rem + in_pl.num;
			end
		end
		nx.k = {in_pl.k[K_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pl <= nx;
		end
	end

endmodule
